>>> rtl/median_depth_compare_top_defines.svh
// Assertion macros shared by the median depth compare RTL.
// Depends on nothing; users must provide clk and rst_n in scope.
`ifndef MEDIAN_DEPTH_COMPARE_TOP_DEFINES_SVH
`define MEDIAN_DEPTH_COMPARE_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define MDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define MDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mdc_pkg.sv
// Package for the median depth compare block: word types, cell control, constants.
// Depends on nothing.
package mdc_pkg;

  localparam int DEPTH_W         = 32;
  localparam int MAX_MATCHES_DEF = 256;

  typedef logic signed [DEPTH_W-1:0] depth_t;

  localparam depth_t THRESH_RESET = 32'sh0001_0000;

  typedef struct packed {
    depth_t depth_a;
    depth_t depth_b;
    logic   set_a_ok;
    logic   set_b_ok;
    logic   last;
  } in_word_t;

  typedef struct packed {
    logic   depth_good;
    depth_t median_a;
    depth_t median_b;
  } out_word_t;

  // Per-cycle command broadcast to every cell of a chain.
  typedef struct packed {
    logic ins;
    logic shl;
    logic clr;
  } cell_ctl_t;

endpackage

>>> rtl/median_depth_compare_top.sv
// Top level of the median depth compare block: control, threshold, verdict.
// Depends on mdc_pkg, mdc_chain and median_depth_compare_top_defines.svh.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+----------------------------------
//  in_     | input     | in_valid / in_ready  | in_word_t  (two depths, flags, last)
//  out_    | output    | out_valid / out_ready| out_word_t (verdict, two medians)
//  cfg_    | input     | cfg_valid / cfg_ready| depth_threshold, always accepted
//
//  Loading takes one word per cycle while in_ready is high; each word drops
//  into its sorted place in two rows of MAX_MATCHES cells as it arrives, while
//  the rows have room. After the last word the rows shift towards the head
//  count/2 times, then the verdict is registered; no input is taken meanwhile.
//  A result still waiting in the output register holds the finish step, and
//  in_ready stays low until that result is taken.
//  Reset empties the rows at once through the cell occupancy bits; no sweep.
module median_depth_compare_top #(
  parameter int MAX_MATCHES = mdc_pkg::MAX_MATCHES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mdc_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mdc_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  mdc_pkg::depth_t    cfg_data
);
  import mdc_pkg::*;
  `include "median_depth_compare_top_defines.svh"

  localparam int CW = $clog2(MAX_MATCHES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_MATCHES);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  logic            state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   shift_cnt_r, shift_cnt_nxt;
  logic            a_ok_r, a_ok_nxt;
  logic            b_ok_r, b_ok_nxt;
  depth_t          thresh_r;
  logic            out_valid_r, out_valid_nxt;
  out_word_t       out_data_r, out_data_nxt;

  logic            in_fire;
  logic            full;
  logic [CW-1:0]   cnt_ins;
  logic            finish;
  cell_ctl_t       ctl;
  depth_t          med_a, med_b;
  logic            head_a_vld, head_b_vld;
  logic            good;

  function automatic logic [DEPTH_W:0] mag(input depth_t v);
    logic [DEPTH_W:0] ext;
    ext = {v[DEPTH_W-1], v};
    return v[DEPTH_W-1] ? (~ext + 1'b1) : ext;
  endfunction

  // Configuration: take every write straight away.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_valid) begin
      thresh_r <= cfg_data;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign full     = (cnt_r == MAX_CNT);
  assign cnt_ins  = (in_fire && !full) ? cnt_r + 1'b1 : cnt_r;

  // Finish once the median has reached the head and the output register is free.
  assign finish = (state_r == S_DRAIN) && (shift_cnt_r == '0) &&
                  (!out_valid_r || out_ready);

  always_comb begin
    ctl.ins = in_fire && !full;
    ctl.shl = (state_r == S_DRAIN) && (shift_cnt_r != '0);
    ctl.clr = finish;
  end

  mdc_chain #(.DEPTH(MAX_MATCHES)) u_chain_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .key      (in_data.depth_a),
    .head_val (med_a),
    .head_vld (head_a_vld)
  );

  mdc_chain #(.DEPTH(MAX_MATCHES)) u_chain_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .key      (in_data.depth_b),
    .head_val (med_b),
    .head_vld (head_b_vld)
  );

  // Verdict: flags of the last word override the depth comparison.
  always_comb begin
    if (!a_ok_r) begin
      good = 1'b0;
    end else if (!b_ok_r) begin
      good = 1'b1;
    end else begin
      good = (med_a > thresh_r) &&
             ((med_b < thresh_r) || (mag(med_a) < mag(med_b)));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_ins;
    shift_cnt_nxt = shift_cnt_r;
    a_ok_nxt      = a_ok_r;
    b_ok_nxt      = b_ok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_data.last) begin
          // Hold the flags and count the shifts that bring index count/2 to the head.
          a_ok_nxt      = in_data.set_a_ok;
          b_ok_nxt      = in_data.set_b_ok;
          shift_cnt_nxt = cnt_ins >> 1;
          state_nxt     = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (shift_cnt_r != '0) begin
          shift_cnt_nxt = shift_cnt_r - 1'b1;
        end else if (finish) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.depth_good = good;
          out_data_nxt.median_a   = med_a;
          out_data_nxt.median_b   = med_b;
          cnt_nxt                 = '0;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      shift_cnt_r <= '0;
      a_ok_r      <= 1'b0;
      b_ok_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      shift_cnt_r <= shift_cnt_nxt;
      a_ok_r      <= a_ok_nxt;
      b_ok_r      <= b_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MDC_ASSERT_IMP(a_idle_no_shift, state_r == S_IDLE, shift_cnt_r == '0, "shift count in idle")
  `MDC_ASSERT_NEXT(a_last_drains, in_fire && in_data.last, state_r == S_DRAIN, "drain not started")
  `MDC_ASSERT_IMP(a_out_from_drain, $rose(out_valid_r), $past(state_r) == S_DRAIN, "stray result")
  `MDC_ASSERT_IMP(a_head_filled, cnt_r != '0, head_a_vld && head_b_vld, "empty chain head")

endmodule

>>> rtl/mdc_cell.sv
// One cell of the sorting chain: holds one depth and its occupancy bit.
// Depends on mdc_pkg.
module mdc_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  mdc_pkg::cell_ctl_t ctl,
  input  mdc_pkg::depth_t    key,
  input  mdc_pkg::depth_t    left_val,
  input  logic               left_vld,
  input  logic               left_move,
  input  mdc_pkg::depth_t    right_val,
  output mdc_pkg::depth_t    val,
  output logic               vld,
  output logic               move
);
  import mdc_pkg::*;

  depth_t val_r, val_nxt;
  logic   vld_r, vld_nxt;

  // Move right on insertion when empty or holding a larger depth.
  assign move = !vld_r || (key < val_r);

  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (ctl.clr) begin
      vld_nxt = 1'b0;
    end else if (ctl.shl) begin
      val_nxt = right_val;
    end else if (ctl.ins && move && (vld_r || left_vld)) begin
      val_nxt = left_move ? left_val : key;
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign val = val_r;
  assign vld = vld_r;

endmodule

>>> rtl/mdc_chain.sv
// Row of sorting cells for one depth set, kept in ascending order.
// Depends on mdc_pkg and mdc_cell.
module mdc_chain #(
  parameter int DEPTH = mdc_pkg::MAX_MATCHES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mdc_pkg::cell_ctl_t ctl,
  input  mdc_pkg::depth_t    key,
  output mdc_pkg::depth_t    head_val,
  output logic               head_vld
);
  import mdc_pkg::*;

  depth_t val_w  [DEPTH];
  logic   vld_w  [DEPTH];
  logic   move_w [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    depth_t lval, rval;
    logic   lvld, lmove;

    if (i == 0) begin : g_first
      assign lval  = key;
      assign lvld  = 1'b1;
      assign lmove = 1'b0;
    end else begin : g_mid
      assign lval  = val_w[i-1];
      assign lvld  = vld_w[i-1];
      assign lmove = move_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rval = val_w[i];
    end else begin : g_body
      assign rval = val_w[i+1];
    end

    mdc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .key       (key),
      .left_val  (lval),
      .left_vld  (lvld),
      .left_move (lmove),
      .right_val (rval),
      .val       (val_w[i]),
      .vld       (vld_w[i]),
      .move      (move_w[i])
    );
  end

  assign head_val = val_w[0];
  assign head_vld = vld_w[0];

endmodule
